// File: design/lmrm_pkg.sv
package lmrm_pkg;

    localparam int MAX_WIDTH_DEFAULT  = 4096;
    localparam int MAX_HEIGHT_DEFAULT = 4096;

    localparam int PIXEL_W    = 8;
    localparam int SIZE_W     = 13;
    localparam int LABEL_W    = 8;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 2;

    localparam int AREA_W = 25;
    localparam int SX_W   = 35;
    localparam int SY_W   = 35;
    localparam int SXX_W  = 47;
    localparam int SXY_W  = 46;
    localparam int SYY_W  = 47;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LABEL_VALUE  = 2'd2;

    localparam logic [SIZE_W-1:0]  FRAME_WIDTH_RESET  = 13'd4096;
    localparam logic [SIZE_W-1:0]  FRAME_HEIGHT_RESET = 13'd4096;
    localparam logic [LABEL_W-1:0] LABEL_VALUE_RESET  = 8'd0;

endpackage

// File: design/label_mask_raw_moments.sv
// Raw second-order moments of one label in a streamed label frame.
//
// Input channel: in_valid / in_stall / pixel, one label pixel per transfer in
// row-major order. Internal column and row counters give each pixel's position.
// Configuration: cfg_wr_en with cfg_index / cfg_data writes frame_width (0),
// frame_height (1) or label_value (2); other indexes are ignored. Sizes of 0
// act as 1, sizes above MAX_WIDTH / MAX_HEIGHT act as the maximum.
// Output channel: out_valid / out_stall with area, sum_x, sum_y, sum_xx,
// sum_xy, sum_yy; one transfer per frame, carrying the totals over the frame.
//
// Throughput: one pixel per cycle while in_stall is low. Three register stages
// (input capture, product, accumulate/result); the totals are registered when
// the last pixel of a frame moves from the product to the result stage. The
// next frame streams in while a result waits; only when a second frame end
// reaches the product stage while the result register is still held does
// in_stall rise, until out_stall drops.
// Reset clears counters, accumulators and pipeline valids and loads the
// default configuration (4096 x 4096, label 0).
module label_mask_raw_moments #(
    parameter int MAX_WIDTH  = lmrm_pkg::MAX_WIDTH_DEFAULT,
    parameter int MAX_HEIGHT = lmrm_pkg::MAX_HEIGHT_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [lmrm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lmrm_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [lmrm_pkg::PIXEL_W-1:0]       pixel,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [lmrm_pkg::AREA_W-1:0]        area,
    output logic [lmrm_pkg::SX_W-1:0]          sum_x,
    output logic [lmrm_pkg::SY_W-1:0]          sum_y,
    output logic [lmrm_pkg::SXX_W-1:0]         sum_xx,
    output logic [lmrm_pkg::SXY_W-1:0]         sum_xy,
    output logic [lmrm_pkg::SYY_W-1:0]         sum_yy
);

    localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int PXX_W = 2 * CW;
    localparam int PXY_W = CW + RW;
    localparam int PYY_W = 2 * RW;

    // configuration
    logic [lmrm_pkg::SIZE_W-1:0]  frame_width_reg;
    logic [lmrm_pkg::SIZE_W-1:0]  frame_height_reg;
    logic [lmrm_pkg::LABEL_W-1:0] label_value_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= lmrm_pkg::FRAME_WIDTH_RESET;
            frame_height_reg <= lmrm_pkg::FRAME_HEIGHT_RESET;
            label_value_reg  <= lmrm_pkg::LABEL_VALUE_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                lmrm_pkg::REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                lmrm_pkg::REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                lmrm_pkg::REG_LABEL_VALUE:
                    label_value_reg <= cfg_data[lmrm_pkg::LABEL_W-1:0];
                default: ;
            endcase
        end
    end

    // effective sizes
    logic [CW:0] width_eff;
    logic [RW:0] height_eff;

    always_comb
    begin
        if (frame_width_reg == '0)
            width_eff = (CW+1)'(1);
        else if (32'(frame_width_reg) > MAX_WIDTH)
            width_eff = (CW+1)'(MAX_WIDTH);
        else
            width_eff = (CW+1)'(frame_width_reg);

        if (frame_height_reg == '0)
            height_eff = (RW+1)'(1);
        else if (32'(frame_height_reg) > MAX_HEIGHT)
            height_eff = (RW+1)'(MAX_HEIGHT);
        else
            height_eff = (RW+1)'(frame_height_reg);
    end

    // handshake and stage movement
    logic a_valid_reg, b_valid_reg, out_valid_reg;
    logic b_last_reg;
    logic in_fire, a_fire, b_take, b_free;

    assign b_take   = b_valid_reg && !(b_last_reg && out_valid_reg && out_stall);
    assign b_free   = !b_valid_reg || b_take;
    assign a_fire   = a_valid_reg && b_free;
    assign in_stall = a_valid_reg && !b_free;
    assign in_fire  = in_valid && !in_stall;

    // position counters
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic          row_end, frame_end, in_last;

    assign row_end   = ({1'b0, col_reg} + (CW+1)'(1)) >= width_eff;
    assign frame_end = ({1'b0, row_reg} + (RW+1)'(1)) >= height_eff;
    assign in_last   = row_end && frame_end;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (in_fire)
        begin
            if (row_end)
            begin
                col_next = '0;
                row_next = frame_end ? '0 : row_reg + RW'(1);
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // stage A: captured pixel position and match
    logic          a_match_reg, a_last_reg;
    logic [CW-1:0] a_x_reg;
    logic [RW-1:0] a_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (in_fire)
            a_valid_reg <= 1'b1;
        else if (a_fire)
            a_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            a_match_reg <= (pixel == label_value_reg);
            a_last_reg  <= in_last;
            a_x_reg     <= col_reg;
            a_y_reg     <= row_reg;
        end
    end

    // stage B: products
    logic             b_match_reg;
    logic [CW-1:0]    b_x_reg;
    logic [RW-1:0]    b_y_reg;
    logic [PXX_W-1:0] b_xx_reg;
    logic [PXY_W-1:0] b_xy_reg;
    logic [PYY_W-1:0] b_yy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_valid_reg <= 1'b0;
        else if (a_fire)
            b_valid_reg <= 1'b1;
        else if (b_take)
            b_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (a_fire)
        begin
            b_match_reg <= a_match_reg;
            b_last_reg  <= a_last_reg;
            b_x_reg     <= a_x_reg;
            b_y_reg     <= a_y_reg;
            b_xx_reg    <= PXX_W'(a_x_reg) * PXX_W'(a_x_reg);
            b_xy_reg    <= PXY_W'(a_x_reg) * PXY_W'(a_y_reg);
            b_yy_reg    <= PYY_W'(a_y_reg) * PYY_W'(a_y_reg);
        end
    end

    // stage C: accumulators and result register
    logic [lmrm_pkg::AREA_W-1:0] acc_area_reg, area_next;
    logic [lmrm_pkg::SX_W-1:0]   acc_x_reg, x_next;
    logic [lmrm_pkg::SY_W-1:0]   acc_y_reg, y_next;
    logic [lmrm_pkg::SXX_W-1:0]  acc_xx_reg, xx_next;
    logic [lmrm_pkg::SXY_W-1:0]  acc_xy_reg, xy_next;
    logic [lmrm_pkg::SYY_W-1:0]  acc_yy_reg, yy_next;

    logic [lmrm_pkg::AREA_W-1:0] area_reg;
    logic [lmrm_pkg::SX_W-1:0]   sum_x_reg;
    logic [lmrm_pkg::SY_W-1:0]   sum_y_reg;
    logic [lmrm_pkg::SXX_W-1:0]  sum_xx_reg;
    logic [lmrm_pkg::SXY_W-1:0]  sum_xy_reg;
    logic [lmrm_pkg::SYY_W-1:0]  sum_yy_reg;

    always_comb
    begin
        area_next = acc_area_reg;
        x_next    = acc_x_reg;
        y_next    = acc_y_reg;
        xx_next   = acc_xx_reg;
        xy_next   = acc_xy_reg;
        yy_next   = acc_yy_reg;
        if (b_match_reg)
        begin
            area_next = acc_area_reg + lmrm_pkg::AREA_W'(1);
            x_next    = acc_x_reg  + lmrm_pkg::SX_W'(b_x_reg);
            y_next    = acc_y_reg  + lmrm_pkg::SY_W'(b_y_reg);
            xx_next   = acc_xx_reg + lmrm_pkg::SXX_W'(b_xx_reg);
            xy_next   = acc_xy_reg + lmrm_pkg::SXY_W'(b_xy_reg);
            yy_next   = acc_yy_reg + lmrm_pkg::SYY_W'(b_yy_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_area_reg <= '0;
            acc_x_reg    <= '0;
            acc_y_reg    <= '0;
            acc_xx_reg   <= '0;
            acc_xy_reg   <= '0;
            acc_yy_reg   <= '0;
        end
        else if (b_take)
        begin
            // frame end restarts the totals for the next frame
            acc_area_reg <= b_last_reg ? '0 : area_next;
            acc_x_reg    <= b_last_reg ? '0 : x_next;
            acc_y_reg    <= b_last_reg ? '0 : y_next;
            acc_xx_reg   <= b_last_reg ? '0 : xx_next;
            acc_xy_reg   <= b_last_reg ? '0 : xy_next;
            acc_yy_reg   <= b_last_reg ? '0 : yy_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (b_take && b_last_reg)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (b_take && b_last_reg)
        begin
            area_reg   <= area_next;
            sum_x_reg  <= x_next;
            sum_y_reg  <= y_next;
            sum_xx_reg <= xx_next;
            sum_xy_reg <= xy_next;
            sum_yy_reg <= yy_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign area      = area_reg;
    assign sum_x     = sum_x_reg;
    assign sum_y     = sum_y_reg;
    assign sum_xx    = sum_xx_reg;
    assign sum_xy    = sum_xy_reg;
    assign sum_yy    = sum_yy_reg;

`ifndef SYNTHESIS
    ast_counter_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(col_reg) < MAX_WIDTH) && (32'(row_reg) < MAX_HEIGHT))
        else $error("position counter beyond frame maximum");

    ast_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && in_last |=> (col_reg == '0) && (row_reg == '0))
        else $error("counters not cleared after last pixel");

    ast_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> a_valid_reg && b_valid_reg && b_last_reg && out_valid_reg)
        else $error("input stalled without a held frame result");

    ast_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(b_take && b_last_reg))
        else $error("result raised without a frame end");

    ast_acc_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        b_take && b_last_reg |=> (acc_area_reg == '0) && (acc_xx_reg == '0))
        else $error("accumulators not cleared at frame end");
`endif

endmodule

// File: sim/moments_checker.sv
`timescale 1ns / 100ps

module moments_checker #(
    parameter int MAX_WIDTH  = lmrm_pkg::MAX_WIDTH_DEFAULT,
    parameter int MAX_HEIGHT = lmrm_pkg::MAX_HEIGHT_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [lmrm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lmrm_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            in_valid,
    input  logic                            in_stall,
    input  logic [lmrm_pkg::PIXEL_W-1:0]    pixel,
    input  logic                            out_valid,
    input  logic                            out_stall,
    input  logic [lmrm_pkg::AREA_W-1:0]     area,
    input  logic [lmrm_pkg::SX_W-1:0]       sum_x,
    input  logic [lmrm_pkg::SY_W-1:0]       sum_y,
    input  logic [lmrm_pkg::SXX_W-1:0]      sum_xx,
    input  logic [lmrm_pkg::SXY_W-1:0]      sum_xy,
    input  logic [lmrm_pkg::SYY_W-1:0]      sum_yy,
    output int                              mismatches,
    output int                              totals_pending,
    output int                              frames_done
);

    typedef struct packed {
        logic [lmrm_pkg::AREA_W-1:0] area;
        logic [lmrm_pkg::SX_W-1:0]   sum_x;
        logic [lmrm_pkg::SY_W-1:0]   sum_y;
        logic [lmrm_pkg::SXX_W-1:0]  sum_xx;
        logic [lmrm_pkg::SXY_W-1:0]  sum_xy;
        logic [lmrm_pkg::SYY_W-1:0]  sum_yy;
    } moments_t;

    moments_t expected_totals[$];

    logic [lmrm_pkg::SIZE_W-1:0]  width_reg;
    logic [lmrm_pkg::SIZE_W-1:0]  height_reg;
    logic [lmrm_pkg::LABEL_W-1:0] label_reg;

    int unsigned col_pos;
    int unsigned row_pos;
    logic [63:0] run_area;
    logic [63:0] run_x;
    logic [63:0] run_y;
    logic [63:0] run_xx;
    logic [63:0] run_xy;
    logic [63:0] run_yy;

    function automatic int unsigned eff_size(logic [lmrm_pkg::SIZE_W-1:0] v,
                                             int unsigned lim);
        if (v == '0)
            return 1;
        if (32'(v) > lim)
            return lim;
        return 32'(v);
    endfunction

    task automatic clear_frame();
        col_pos = 0;
        row_pos = 0;
        run_area = '0;
        run_x = '0;
        run_y = '0;
        run_xx = '0;
        run_xy = '0;
        run_yy = '0;
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    // One accepted pixel: accumulate, then advance the raster position.
    task automatic accumulate_pixel(input logic [lmrm_pkg::PIXEL_W-1:0] value);
        int unsigned w;
        int unsigned h;
        logic [63:0] x;
        logic [63:0] y;
        moments_t t;
        w = eff_size(width_reg, MAX_WIDTH);
        h = eff_size(height_reg, MAX_HEIGHT);
        x = 64'(col_pos);
        y = 64'(row_pos);
        if (value == label_reg) begin
            run_area += 64'd1;
            run_x += x;
            run_y += y;
            run_xx += x * x;
            run_xy += x * y;
            run_yy += y * y;
        end
        // a counter already past a shrunk size ends its row/frame here
        if (col_pos + 1 >= w) begin
            col_pos = 0;
            if (row_pos + 1 >= h) begin
                t.area   = run_area[lmrm_pkg::AREA_W-1:0];
                t.sum_x  = run_x[lmrm_pkg::SX_W-1:0];
                t.sum_y  = run_y[lmrm_pkg::SY_W-1:0];
                t.sum_xx = run_xx[lmrm_pkg::SXX_W-1:0];
                t.sum_xy = run_xy[lmrm_pkg::SXY_W-1:0];
                t.sum_yy = run_yy[lmrm_pkg::SYY_W-1:0];
                expected_totals.push_back(t);
                totals_pending++;
                clear_frame();
            end else begin
                row_pos++;
            end
        end else begin
            col_pos++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        moments_t want;
        if (!rst_n) begin
            width_reg = lmrm_pkg::FRAME_WIDTH_RESET;
            height_reg = lmrm_pkg::FRAME_HEIGHT_RESET;
            label_reg = lmrm_pkg::LABEL_VALUE_RESET;
            clear_frame();
            expected_totals.delete();
            totals_pending = 0;
            mismatches = 0;
            frames_done = 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    lmrm_pkg::REG_FRAME_WIDTH:  width_reg = cfg_data;
                    lmrm_pkg::REG_FRAME_HEIGHT: height_reg = cfg_data;
                    lmrm_pkg::REG_LABEL_VALUE:
                        label_reg = cfg_data[lmrm_pkg::LABEL_W-1:0];
                    default: ;
                endcase
            end
            if (out_valid && !out_stall) begin
                if (expected_totals.size() == 0) begin
                    report_mismatch("result with no frame pending", 64'(area), 64'd0);
                end else begin
                    want = expected_totals.pop_front();
                    totals_pending--;
                    frames_done++;
                    if (area !== want.area)
                        report_mismatch("area", 64'(area), 64'(want.area));
                    if (sum_x !== want.sum_x)
                        report_mismatch("sum_x", 64'(sum_x), 64'(want.sum_x));
                    if (sum_y !== want.sum_y)
                        report_mismatch("sum_y", 64'(sum_y), 64'(want.sum_y));
                    if (sum_xx !== want.sum_xx)
                        report_mismatch("sum_xx", 64'(sum_xx), 64'(want.sum_xx));
                    if (sum_xy !== want.sum_xy)
                        report_mismatch("sum_xy", 64'(sum_xy), 64'(want.sum_xy));
                    if (sum_yy !== want.sum_yy)
                        report_mismatch("sum_yy", 64'(sum_yy), 64'(want.sum_yy));
                end
            end
            if (in_valid && !in_stall)
                accumulate_pixel(pixel);
        end
    end

endmodule

// File: sim/tb_label_mask_raw_moments.sv
`timescale 1ns / 100ps

module tb_label_mask_raw_moments;

    localparam int PIPE_SETTLE = 8;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            cfg_wr_en = 1'b0;
    logic [lmrm_pkg::CFG_IDX_W-1:0]  cfg_index = lmrm_pkg::REG_FRAME_WIDTH;
    logic [lmrm_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic                            in_valid = 1'b0;
    logic                            in_stall;
    logic [lmrm_pkg::PIXEL_W-1:0]    pixel = '0;
    logic                            out_valid;
    logic                            out_stall = 1'b0;
    logic [lmrm_pkg::AREA_W-1:0]     area;
    logic [lmrm_pkg::SX_W-1:0]       sum_x;
    logic [lmrm_pkg::SY_W-1:0]       sum_y;
    logic [lmrm_pkg::SXX_W-1:0]      sum_xx;
    logic [lmrm_pkg::SXY_W-1:0]      sum_xy;
    logic [lmrm_pkg::SYY_W-1:0]      sum_yy;

    int mismatches;
    int totals_pending;
    int frames_done;

    int gap_pct = 0;
    int stall_pct = 0;
    int pixels_sent = 0;
    int reg_writes = 0;

    label_mask_raw_moments u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .pixel     (pixel),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .area      (area),
        .sum_x     (sum_x),
        .sum_y     (sum_y),
        .sum_xx    (sum_xx),
        .sum_xy    (sum_xy),
        .sum_yy    (sum_yy)
    );

    moments_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .pixel          (pixel),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .area           (area),
        .sum_x          (sum_x),
        .sum_y          (sum_y),
        .sum_xx         (sum_xx),
        .sum_xy         (sum_xy),
        .sum_yy         (sum_yy),
        .mismatches     (mismatches),
        .totals_pending (totals_pending),
        .frames_done    (frames_done)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end

    // 0: none, 1: sender gaps, 2: receiver stalls, 3: both, light
    task automatic set_idle_mix(input int mix);
        case (mix)
            1:       begin gap_pct = 86; stall_pct = 0;  end
            2:       begin gap_pct = 0;  stall_pct = 86; end
            3:       begin gap_pct = 22; stall_pct = 22; end
            default: begin gap_pct = 0;  stall_pct = 0;  end
        endcase
    endtask

    task automatic push_pixel(input logic [lmrm_pkg::PIXEL_W-1:0] value);
        while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        pixel <= value;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pixels_sent++;
    endtask

    function automatic logic [lmrm_pkg::PIXEL_W-1:0] pick_pixel(
        input logic [lmrm_pkg::LABEL_W-1:0] lbl, input int hit_pct);
        if ($urandom_range(99) < hit_pct)
            return lbl;
        return lmrm_pkg::PIXEL_W'($urandom_range(255));
    endfunction

    // Drain all pending totals, then let the pipeline empty before a register write.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (totals_pending != 0)
            @(posedge clk);
        repeat (PIPE_SETTLE) @(posedge clk);
    endtask

    // caller lowers cfg_wr_en after the last write of a batch
    task automatic write_reg(input logic [lmrm_pkg::CFG_IDX_W-1:0] idx,
                             input logic [lmrm_pkg::CFG_DATA_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        reg_writes++;
    endtask

    initial
    begin
        int n;
        int mix;
        logic [lmrm_pkg::LABEL_W-1:0] lbl;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // default 4096x4096: stop mid-row, then shrink width below the column
        push_pixel(8'h00);
        push_pixel(8'hFF);
        push_pixel(8'h00);
        push_pixel(8'h55);
        push_pixel(8'hAA);
        settle();
        write_reg(lmrm_pkg::REG_FRAME_WIDTH, 13'd2);
        write_reg(lmrm_pkg::REG_FRAME_HEIGHT, 13'd0);
        cfg_wr_en <= 1'b0;
        push_pixel(8'h00);

        // one pixel per frame, top label, unused index written
        settle();
        write_reg(lmrm_pkg::REG_FRAME_WIDTH, 13'd1);
        write_reg(lmrm_pkg::REG_FRAME_HEIGHT, 13'd1);
        write_reg(lmrm_pkg::REG_LABEL_VALUE, 13'h0FF);
        write_reg(2'd3, 13'h1FFF);
        cfg_wr_en <= 1'b0;
        push_pixel(8'hFF);
        push_pixel(8'h00);
        push_pixel(8'hFE);
        push_pixel(8'hFF);

        settle();
        write_reg(lmrm_pkg::REG_FRAME_WIDTH, 13'd3);
        write_reg(lmrm_pkg::REG_FRAME_HEIGHT, 13'd2);
        write_reg(lmrm_pkg::REG_LABEL_VALUE, 13'h05A);
        cfg_wr_en <= 1'b0;
        push_pixel(8'h5A);
        push_pixel(8'h5A);
        push_pixel(8'hA5);
        push_pixel(8'h5A);
        push_pixel(8'h5A);
        push_pixel(8'h5A);

        // height shrinks and label changes with the frame partly done
        settle();
        write_reg(lmrm_pkg::REG_FRAME_WIDTH, 13'd2);
        write_reg(lmrm_pkg::REG_FRAME_HEIGHT, 13'd4);
        write_reg(lmrm_pkg::REG_LABEL_VALUE, 13'h033);
        cfg_wr_en <= 1'b0;
        push_pixel(8'h33);
        push_pixel(8'hCC);
        push_pixel(8'h33);
        push_pixel(8'h33);
        push_pixel(8'h33);
        settle();
        write_reg(lmrm_pkg::REG_FRAME_HEIGHT, 13'd2);
        write_reg(lmrm_pkg::REG_LABEL_VALUE, 13'h1CC);
        cfg_wr_en <= 1'b0;
        push_pixel(8'hCC);

        // random small frames; phases often end mid-frame before the next setting
        mix = 0;
        n = 0;
        while (n < 450) begin
            settle();
            set_idle_mix(mix % 4);
            mix++;
            lbl = lmrm_pkg::LABEL_W'($urandom_range(255));
            write_reg(lmrm_pkg::REG_FRAME_WIDTH, lmrm_pkg::CFG_DATA_W'($urandom_range(0, 6)));
            write_reg(lmrm_pkg::REG_FRAME_HEIGHT, lmrm_pkg::CFG_DATA_W'($urandom_range(0, 5)));
            write_reg(lmrm_pkg::REG_LABEL_VALUE, {5'($urandom), lbl});
            if ($urandom_range(7) == 0)
                write_reg(2'd3, lmrm_pkg::CFG_DATA_W'($urandom_range(8191)));
            cfg_wr_en <= 1'b0;
            repeat ($urandom_range(4, 40)) begin
                push_pixel(pick_pixel(lbl, 50));
                n++;
            end
        end

        // oversize sizes act as the maximum; a shrink then closes the open frame
        settle();
        set_idle_mix(3);
        write_reg(lmrm_pkg::REG_FRAME_WIDTH, 13'h1FFF);
        write_reg(lmrm_pkg::REG_FRAME_HEIGHT, 13'h1FFF);
        write_reg(lmrm_pkg::REG_LABEL_VALUE, 13'h0A7);
        cfg_wr_en <= 1'b0;
        repeat (30) push_pixel(pick_pixel(8'hA7, 90));
        settle();
        write_reg(lmrm_pkg::REG_FRAME_WIDTH, 13'd1);
        write_reg(lmrm_pkg::REG_FRAME_HEIGHT, 13'd1);
        cfg_wr_en <= 1'b0;
        push_pixel(8'hA7);
        settle();
        write_reg(lmrm_pkg::REG_FRAME_WIDTH, 13'd1);
        write_reg(lmrm_pkg::REG_FRAME_HEIGHT, 13'd5000);
        write_reg(lmrm_pkg::REG_LABEL_VALUE, 13'h000);
        cfg_wr_en <= 1'b0;
        repeat (20) push_pixel(pick_pixel(8'h00, 97));
        settle();
        write_reg(lmrm_pkg::REG_FRAME_HEIGHT, 13'd1);
        cfg_wr_en <= 1'b0;
        push_pixel(8'h00);

        in_valid <= 1'b0;
        @(posedge clk);
        for (int i = 0; i < 4000 && totals_pending != 0; i++)
            @(posedge clk);
        repeat (PIPE_SETTLE) @(posedge clk);

        $display("Streamed %0d pixels, %0d frame totals checked, %0d register writes,",
                 pixels_sent, frames_done, reg_writes);
        $display("across idle-free, sender-gap, receiver-stall and mixed phases.");
        if (mismatches == 0 && totals_pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #8000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
